// ----- sv/ttip_pkg.sv -----
// Package for the token to integer parser: payload types, codes and character helpers.
package ttip_pkg;

    // Input item: one payload byte and its end marker
    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
    } t_in;

    // Result item
    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
        logic        end_of_payload;
    } t_out;

    // Configuration register set
    typedef struct packed {
        logic [1:0] number_base;
        logic       signed_mode;
    } t_cfg;

    // Register indexes
    localparam logic CFG_NUMBER_BASE = 1'b0;
    localparam logic CFG_SIGNED_MODE = 1'b1;

    // number_base codes
    localparam logic [1:0] BASE_AUTO = 2'd0;
    localparam logic [1:0] BASE_DEC  = 2'd1;
    localparam logic [1:0] BASE_HEX  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_DIGITS = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_NO_TOKEN  = 2'd3;

    // Marker for a byte that is no digit in any base
    localparam logic [7:0] DIGIT_NONE = 8'd255;

    // Parser phase
    typedef enum logic [2:0] {
        PH_SKIP_FRESH,
        PH_SKIP_AFTER,
        PH_LEAD,
        PH_AFTER_SIGN,
        PH_ZERO,
        PH_X,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    // Base in force for the current token
    typedef enum logic [1:0] {
        EB_UNSET,
        EB_DEC,
        EB_HEX,
        EB_OCT
    } t_eb;

    // Space, tab, CR and LF split tokens
    function automatic logic is_separator(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    endfunction

    // Digit value of a character, up to 35, or DIGIT_NONE
    function automatic logic [7:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = DIGIT_NONE;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
        end else if (c inside {[8'h61:8'h7A]}) begin
            d = c - 8'h61 + 8'd10;
        end else if (c inside {[8'h41:8'h5A]}) begin
            d = c - 8'h41 + 8'd10;
        end
        return d;
    endfunction

    // Radix of an effective base; unset counts as decimal
    function automatic logic [4:0] radix_of(input t_eb eb);
        logic [4:0] r;
        case (eb)
            EB_HEX:  r = 5'd16;
            EB_OCT:  r = 5'd8;
            default: r = 5'd10;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/ttip_parse.sv -----
// Parser core: token state, per-byte update and the result register.
module ttip_parse #(
    parameter int MAX_TOKEN_CHARS = 255
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ttip_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  ttip_pkg::t_in i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output ttip_pkg::t_out o_data
);
    import ttip_pkg::*;

    localparam int CW = $clog2(MAX_TOKEN_CHARS + 1);

    t_phase        r_phase, n_phase;
    logic [31:0]   r_acc, n_acc;
    logic          r_neg, n_neg;
    logic          r_dig, n_dig;
    logic          r_ovf, n_ovf;
    t_eb           r_eb, n_eb;
    logic [CW-1:0] r_chars, n_chars;

    logic          r_out_valid;
    t_out          r_out;

    logic          w_step;
    logic          w_sep;
    logic          w_tok;
    logic          w_do_acc;
    logic          w_emit;
    logic          w_emit_none;
    logic [7:0]    w_c;
    logic [7:0]    w_d;
    logic [35:0]   w_prod;
    logic [35:0]   w_sum;
    logic [35:0]   w_limit;
    t_out          w_res;

    // Transfer into the core when the result register is free or being drained
    assign o_ready = !r_out_valid || i_ready;
    assign w_step  = i_valid && o_ready;
    assign w_c     = i_data.char_byte;
    assign w_d     = digit_of(w_c);
    assign w_sep   = is_separator(w_c);

    // Next state for one byte
    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_dig       = r_dig;
        n_ovf       = r_ovf;
        n_eb        = r_eb;
        n_chars     = r_chars;
        w_tok       = 1'b0;
        w_do_acc    = 1'b0;
        w_emit      = 1'b0;
        w_emit_none = 1'b0;
        w_prod      = '0;
        w_sum       = '0;
        w_limit     = '0;

        if (r_phase == PH_SKIP_FRESH || r_phase == PH_SKIP_AFTER) begin
            if (w_sep) begin
                if (i_data.last_byte) begin
                    if (r_phase == PH_SKIP_FRESH) begin
                        w_emit_none = 1'b1;
                    end else begin
                        n_phase = PH_SKIP_FRESH;
                    end
                end
            end else begin
                // Start a token
                n_acc   = '0;
                n_neg   = 1'b0;
                n_dig   = 1'b0;
                n_ovf   = 1'b0;
                n_chars = '0;
                if (i_cfg.number_base == BASE_HEX) begin
                    n_eb = EB_HEX;
                end else if (i_cfg.number_base == BASE_AUTO) begin
                    n_eb = EB_UNSET;
                end else begin
                    n_eb = EB_DEC;
                end
                n_phase = PH_LEAD;
                w_tok   = 1'b1;
            end
        end else begin
            if (w_sep) begin
                w_emit  = 1'b1;
                n_phase = i_data.last_byte ? PH_SKIP_FRESH : PH_SKIP_AFTER;
            end else begin
                w_tok = 1'b1;
            end
        end

        // Token byte, counted up to the length limit
        if (w_tok && (n_chars < CW'(MAX_TOKEN_CHARS))) begin
            n_chars = n_chars + 1'b1;
            case (n_phase)
                PH_LEAD, PH_AFTER_SIGN: begin
                    if (n_phase == PH_LEAD && (w_c == 8'h0B || w_c == 8'h0C)) begin
                        n_phase = PH_LEAD;
                    end else if (n_phase == PH_LEAD && w_c == 8'h2B) begin
                        n_phase = PH_AFTER_SIGN;
                    end else if (n_phase == PH_LEAD && w_c == 8'h2D) begin
                        n_neg   = 1'b1;
                        n_phase = PH_AFTER_SIGN;
                    end else if (w_c == 8'h30 && (n_eb == EB_UNSET || n_eb == EB_HEX)) begin
                        n_dig   = 1'b1;
                        n_phase = PH_ZERO;
                    end else begin
                        if (n_eb == EB_UNSET && w_d >= 8'd1 && w_d <= 8'd9) begin
                            n_eb = EB_DEC;
                        end
                        if (n_eb != EB_UNSET && w_d < {3'b000, radix_of(n_eb)}) begin
                            w_do_acc = 1'b1;
                            n_phase  = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_ZERO: begin
                    if (w_c == 8'h78 || w_c == 8'h58) begin
                        n_phase = PH_X;
                    end else begin
                        if (n_eb == EB_UNSET) begin
                            n_eb = EB_OCT;
                        end
                        if (w_d < {3'b000, radix_of(n_eb)}) begin
                            w_do_acc = 1'b1;
                            n_phase  = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_X: begin
                    n_eb = EB_HEX;
                    if (w_d < 8'd16) begin
                        w_do_acc = 1'b1;
                        n_phase  = PH_DIGITS;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (w_d < {3'b000, radix_of(n_eb)}) begin
                        w_do_acc = 1'b1;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end

        // Shift-add accumulate with saturation check
        if (w_do_acc) begin
            n_dig = 1'b1;
            case (n_eb)
                EB_HEX:  w_prod = {n_acc, 4'b0000};
                EB_OCT:  w_prod = {1'b0, n_acc, 3'b000};
                default: w_prod = {1'b0, n_acc, 3'b000} + {3'b000, n_acc, 1'b0};
            endcase
            w_sum = w_prod + {28'd0, w_d};
            if (i_cfg.signed_mode) begin
                w_limit = n_neg ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;
            end else begin
                w_limit = 36'h0_FFFF_FFFF;
            end
            if (!n_ovf) begin
                if (w_sum > w_limit) begin
                    n_ovf = 1'b1;
                end else begin
                    n_acc = w_sum[31:0];
                end
            end
        end

        // Payload end closes an open token
        if (w_tok && i_data.last_byte) begin
            w_emit  = 1'b1;
            n_phase = PH_SKIP_FRESH;
        end
    end

    // Result for the token as it stands after this byte
    always_comb begin
        w_res.end_of_payload = i_data.last_byte;
        if (w_emit_none) begin
            w_res.value  = '0;
            w_res.status = ST_NO_TOKEN;
        end else if (!n_dig) begin
            w_res.value  = '0;
            w_res.status = ST_NO_DIGITS;
        end else if (n_ovf) begin
            w_res.status = ST_OVERFLOW;
            if (i_cfg.signed_mode) begin
                w_res.value = n_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                w_res.value = 32'hFFFF_FFFF;
            end
        end else begin
            w_res.status = ST_OK;
            w_res.value  = n_neg ? (32'd0 - n_acc) : n_acc;
        end
    end

    // Advance token state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP_FRESH;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_dig   <= 1'b0;
            r_ovf   <= 1'b0;
            r_eb    <= EB_UNSET;
            r_chars <= '0;
        end else if (w_step) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_dig   <= n_dig;
            r_ovf   <= n_ovf;
            r_eb    <= n_eb;
            r_chars <= n_chars;
        end
    end

    // Result register: load on a result, drop after its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_emit || w_emit_none;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && (w_emit || w_emit_none)) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Token length counter stays within its limit
    a_chars_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chars <= CW'(MAX_TOKEN_CHARS))
        else $error("token char count above limit");

    // Digits are only taken with a known base
    a_digits_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DIGITS) |-> (r_eb != EB_UNSET))
        else $error("digit phase without a base");

    // A payload end always returns to the fresh skip phase
    a_last_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && i_data.last_byte) |=> (r_phase == PH_SKIP_FRESH))
        else $error("phase not fresh after payload end");

    // No-token and no-digit results carry a zero value; no-token ends a payload
    a_zero_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == ST_NO_TOKEN || r_out.status == ST_NO_DIGITS))
        |-> (r_out.value == 32'd0
             && (r_out.status != ST_NO_TOKEN || r_out.end_of_payload)))
        else $error("bad empty result");

endmodule

// ----- sv/token_to_integer_parser.sv -----
// Top level of the token to integer parser: configuration, input register and parser core.
// A closing byte passes the input register; its result is offered by the result register.
// Throughput: one byte per cycle while the result side is ready; the shift-add and compare
// sit between the input register and the result register. A held result stalls the core.
// Reset: synchronous, active low; clears the configuration registers to auto base and
// unsigned mode, empties both stages and returns the parser to separator skipping.
module token_to_integer_parser #(
    parameter int MAX_TOKEN_CHARS = 255
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [1:0]     i_cfg_wdata,
    input  logic           i_valid,
    output logic           o_ready,
    input  ttip_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output ttip_pkg::t_out o_data
);
    import ttip_pkg::*;

    t_cfg r_cfg;
    logic r_in_valid;
    t_in  r_in;
    logic w_core_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.number_base <= BASE_AUTO;
            r_cfg.signed_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUMBER_BASE: r_cfg.number_base <= i_cfg_wdata;
                CFG_SIGNED_MODE: r_cfg.signed_mode <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Input register: take a byte when empty or when the core takes the held one
    assign o_ready = !r_in_valid || w_core_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_data;
        end
    end

    ttip_parse #(
        .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (r_in_valid),
        .o_ready (w_core_ready),
        .i_data  (r_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
